// File: rtl/oaht_pkg.sv
// Package: sizes, codes and shared types of the open-address hash table.
package oaht_pkg;
    localparam int IndexBits = 10;
    localparam int TableSize = 1 << IndexBits;
    localparam int StepBits  = IndexBits + 1;

    localparam logic [1:0] KIND_EMPTY   = 2'd0;
    localparam logic [1:0] KIND_REMOVED = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_LKINS  = 2'd3;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int EntryBits = 2 + 64 * 3;

    typedef logic [IndexBits-1:0] t_index;

    typedef struct packed {
        logic   clr_we;
        t_index clr_addr;
        logic   load;
        logic   rd_en;
        logic   advance;
        logic   write;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic is_empty;
        logic is_match;
        logic last_step;
    } t_status;
endpackage

// File: rtl/oaht_if.sv
// Interface: valid/ready channel carrying a generic payload.
interface oaht_if #(parameter int Width = 8) (input logic i_clk);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/oaht_ram.sv
// Generic single-port RAM with registered read.
module oaht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/oaht_datapath.sv
// Datapath: probe index, slot memory, tombstone tracking and result register.
module oaht_datapath (
    input  logic             i_clk,
    input  oaht_pkg::t_cmd   i_cmd,
    input  logic [1:0]       i_func,
    input  logic [63:0]      i_key,
    input  logic [63:0]      i_key_hash,
    input  logic [63:0]      i_value,
    output oaht_pkg::t_status o_status,
    output logic [1:0]       o_res_status,
    output logic [63:0]      o_res_value
);
    oaht_pkg::t_index r_idx, r_tomb;
    logic [oaht_pkg::StepBits-1:0] r_step;
    logic r_tomb_seen;
    logic [1:0]  r_func;
    logic [63:0] r_key, r_hash, r_value;
    logic [1:0]  r_res_status;
    logic [63:0] r_res_value;
    logic [oaht_pkg::EntryBits-1:0] w_rdata, w_wdata;
    logic [1:0]  w_kind;
    logic [63:0] w_skey, w_shash, w_sval;
    logic w_we;
    oaht_pkg::t_index w_addr, w_free;
    logic [1:0]  n_res_status;
    logic [63:0] n_res_value;
    logic w_has_free;

    assign {w_kind, w_skey, w_shash, w_sval} = w_rdata;
    assign o_status.is_empty  = (w_kind == oaht_pkg::KIND_EMPTY);
    assign o_status.is_match  = (w_kind == oaht_pkg::KIND_FULL) && (w_shash == r_hash)
                                && (w_skey == r_key);
    assign o_status.last_step = (r_step == oaht_pkg::StepBits'(oaht_pkg::TableSize));

    assign w_free     = (r_tomb_seen || !o_status.is_empty) ? r_tomb : r_idx;
    assign w_has_free = o_status.is_empty || r_tomb_seen
                        || (w_kind == oaht_pkg::KIND_REMOVED);

    always_comb begin
        n_res_status = oaht_pkg::ST_FULL;
        n_res_value  = 64'd0;
        w_wdata      = {oaht_pkg::KIND_FULL, r_key, r_hash, r_value};
        w_addr       = r_idx;
        if (o_status.is_match) begin
            n_res_status = oaht_pkg::ST_FOUND;
            n_res_value  = w_sval;
            if (r_func == oaht_pkg::FUNC_INSERT) begin
                n_res_value = r_value;
            end else if (r_func == oaht_pkg::FUNC_REMOVE) begin
                w_wdata = {oaht_pkg::KIND_REMOVED, w_skey, w_shash, w_sval};
            end else begin
                w_wdata = w_rdata;
            end
        end else if (r_func inside {oaht_pkg::FUNC_LOOKUP, oaht_pkg::FUNC_REMOVE}) begin
            n_res_status = oaht_pkg::ST_MISSING;
        end else if (w_has_free) begin
            n_res_status = oaht_pkg::ST_INSERTED;
            n_res_value  = r_value;
            w_addr       = (w_kind == oaht_pkg::KIND_REMOVED && !r_tomb_seen) ? r_idx : w_free;
        end
        if (i_cmd.clr_we) begin
            w_addr  = i_cmd.clr_addr;
            w_wdata = '0;
        end else if (i_cmd.load) begin
            w_addr = i_key_hash[oaht_pkg::IndexBits-1:0];
        end else if (i_cmd.advance) begin
            w_addr = r_idx + r_step[oaht_pkg::IndexBits-1:0];
        end
    end

    assign w_we = i_cmd.clr_we || (i_cmd.write && (o_status.is_match ||
                  ((r_func inside {oaht_pkg::FUNC_INSERT, oaht_pkg::FUNC_LKINS})
                   && w_has_free)));

    oaht_ram #(.Width(oaht_pkg::EntryBits), .Depth(oaht_pkg::TableSize)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (i_cmd.rd_en),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_key       <= i_key;
            r_hash      <= i_key_hash;
            r_value     <= i_value;
            r_idx       <= i_key_hash[oaht_pkg::IndexBits-1:0];
            r_step      <= oaht_pkg::StepBits'(1);
            r_tomb_seen <= 1'b0;
            r_tomb      <= '0;
        end else if (i_cmd.advance) begin
            if (w_kind == oaht_pkg::KIND_REMOVED && !r_tomb_seen) begin
                r_tomb_seen <= 1'b1;
                r_tomb      <= r_idx;
            end
            r_idx  <= r_idx + r_step[oaht_pkg::IndexBits-1:0];
            r_step <= r_step + oaht_pkg::StepBits'(1);
        end
        if (i_cmd.out_load) begin
            r_res_status <= n_res_status;
            r_res_value  <= n_res_value;
        end
    end

    assign o_res_status = r_res_status;
    assign o_res_value  = r_res_value;
endmodule

// File: rtl/oaht_ctrl.sv
// Controller: clearing pass, probe sequencing and output handshake.
module oaht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  oaht_pkg::t_status i_status,
    output oaht_pkg::t_cmd    o_cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [oaht_pkg::StepBits-1:0] r_clr, n_clr;
    logic r_out_valid, n_out_valid;
    logic w_done;

    assign w_done = i_status.is_match || i_status.is_empty || i_status.last_step;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we   = 1'b1;
                o_cmd.clr_addr = r_clr[oaht_pkg::IndexBits-1:0];
                n_clr          = r_clr + oaht_pkg::StepBits'(1);
                if (r_clr == oaht_pkg::StepBits'(oaht_pkg::TableSize - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_done) begin
                    o_cmd.write    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// File: rtl/open_address_hash_table.sv
// Top level: open-address hash table with triangular probing.
// Each transaction probes 1 to TableSize slots, with one memory read per probe step;
// a new transaction is accepted only once the previous one has finished probing.
// A result that waits on the output holds off the next transaction.
// Reset: synchronous active low; a clearing pass empties every slot,
// and no transaction is accepted until it ends.
module open_address_hash_table (
    input  logic   i_clk,
    input  logic   i_rst_n,
    oaht_if.sink   i_req,
    oaht_if.source o_rsp
);
    oaht_pkg::t_cmd    w_cmd;
    oaht_pkg::t_status w_status;
    logic [1:0]  w_res_status;
    logic [63:0] w_res_value;

    oaht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    oaht_datapath u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_func       (i_req.data[193:192]),
        .i_key        (i_req.data[191:128]),
        .i_key_hash   (i_req.data[127:64]),
        .i_value      (i_req.data[63:0]),
        .o_status     (w_status),
        .o_res_status (w_res_status),
        .o_res_value  (w_res_value)
    );

    assign o_rsp.data = {w_res_status, w_res_value};
endmodule

// File: tb/tb.sv
// Testbench: self-checking test of the open-address hash table against a local predictor.
`timescale 1ns / 100ps

module tb;
    localparam int ReqWidth = 2 + 64 * 3;
    localparam int RspWidth = 2 + 64;
    localparam int CycleLimit = 3000000;
    localparam int PoolSize = 24;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    oaht_if #(.Width(ReqWidth)) req_if (i_clk);
    oaht_if #(.Width(RspWidth)) rsp_if (i_clk);

    open_address_hash_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    logic [1:0]  slot_kind_m  [oaht_pkg::TableSize];
    logic [63:0] slot_key_m   [oaht_pkg::TableSize];
    logic [63:0] slot_hash_m  [oaht_pkg::TableSize];
    logic [63:0] slot_value_m [oaht_pkg::TableSize];

    t_result     pending_results[$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic [63:0] pool_key  [PoolSize];
    logic [63:0] pool_hash [PoolSize];
    logic [63:0] last_key;
    logic [63:0] last_hash;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result apply_request(logic [1:0] func, logic [63:0] key,
                                              logic [63:0] hash, logic [63:0] value);
        oaht_pkg::t_index idx;
        oaht_pkg::t_index tomb;
        oaht_pkg::t_index hit;
        oaht_pkg::t_index free_idx;
        logic      tomb_seen;
        logic      found;
        logic      has_free;
        logic      done;
        t_result   res;
        idx = hash[oaht_pkg::IndexBits-1:0];
        tomb = '0;
        hit = '0;
        free_idx = '0;
        tomb_seen = 1'b0;
        found = 1'b0;
        has_free = 1'b0;
        done = 1'b0;
        for (int step = 1; step <= oaht_pkg::TableSize && !done; step++) begin
            if (slot_kind_m[idx] == oaht_pkg::KIND_FULL) begin
                if (slot_hash_m[idx] == hash && slot_key_m[idx] == key) begin
                    hit = idx;
                    found = 1'b1;
                    done = 1'b1;
                end
            end else if (slot_kind_m[idx] == oaht_pkg::KIND_REMOVED) begin
                if (!tomb_seen) begin
                    tomb_seen = 1'b1;
                    tomb = idx;
                end
            end else if (slot_kind_m[idx] == oaht_pkg::KIND_EMPTY) begin
                free_idx = tomb_seen ? tomb : idx;
                has_free = 1'b1;
                done = 1'b1;
            end
            if (!done) idx = idx + oaht_pkg::t_index'(step);
        end
        if (!done) begin
            free_idx = tomb;
            has_free = tomb_seen;
        end
        res.value = '0;
        if (found) begin
            res.status = oaht_pkg::ST_FOUND;
            if (func == oaht_pkg::FUNC_INSERT) slot_value_m[hit] = value;
            else if (func == oaht_pkg::FUNC_REMOVE) slot_kind_m[hit] = oaht_pkg::KIND_REMOVED;
            res.value = slot_value_m[hit];
        end else if (func == oaht_pkg::FUNC_LOOKUP || func == oaht_pkg::FUNC_REMOVE) begin
            res.status = oaht_pkg::ST_MISSING;
        end else if (has_free) begin
            slot_kind_m[free_idx] = oaht_pkg::KIND_FULL;
            slot_key_m[free_idx] = key;
            slot_hash_m[free_idx] = hash;
            slot_value_m[free_idx] = value;
            res.status = oaht_pkg::ST_INSERTED;
            res.value = value;
        end else begin
            res.status = oaht_pkg::ST_FULL;
        end
        return res;
    endfunction

    function automatic int occupied_slots();
        int n;
        n = 0;
        for (int i = 0; i < oaht_pkg::TableSize; i++) begin
            if (slot_kind_m[i] == oaht_pkg::KIND_FULL) n++;
        end
        return n;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_request(logic [1:0] func, logic [63:0] key, logic [63:0] hash,
                                logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data = {func, key, hash, value};
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(apply_request(func, key, hash, value));
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t timeout", $time);
            $display("tb: errors");
            $finish;
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result status=%0d value=%h", $time,
                         got.status, got.value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) begin
                    $display("%0t status expected %0d actual %0d", $time,
                             want.status, got.status);
                    error_count++;
                end
                if (got.value != want.value) begin
                    $display("%0t value expected %h actual %h", $time,
                             want.value, got.value);
                    error_count++;
                end
            end
        end
    end

    task automatic test_basic_ops();
        send_request(oaht_pkg::FUNC_LOOKUP, '0, '0, '0);
        send_request(oaht_pkg::FUNC_REMOVE, '0, '0, '0);
        send_request(oaht_pkg::FUNC_INSERT, '0, '0, '0);
        send_request(oaht_pkg::FUNC_LOOKUP, '0, '0, '1);
        send_request(oaht_pkg::FUNC_INSERT, '0, '0, '1);
        send_request(oaht_pkg::FUNC_LKINS, '0, '0, 64'h5a5a);
        send_request(oaht_pkg::FUNC_LKINS, '1, '1, '1);
        send_request(oaht_pkg::FUNC_LOOKUP, '1, '1, '0);
        send_request(oaht_pkg::FUNC_REMOVE, '1, '1, '0);
        send_request(oaht_pkg::FUNC_LOOKUP, '1, '1, '0);
        send_request(oaht_pkg::FUNC_REMOVE, '0, '0, '0);
        send_request(oaht_pkg::FUNC_REMOVE, '0, '0, '0);
    endtask

    task automatic test_collisions();
        send_request(oaht_pkg::FUNC_INSERT, 64'h11, 64'h100, 64'ha1);
        send_request(oaht_pkg::FUNC_INSERT, 64'h22, 64'h100, 64'ha2);
        send_request(oaht_pkg::FUNC_INSERT, 64'h33, 64'h100, 64'ha3);
        send_request(oaht_pkg::FUNC_LOOKUP, 64'h11, 64'h500, '0);
        send_request(oaht_pkg::FUNC_REMOVE, 64'h22, 64'h100, '0);
        send_request(oaht_pkg::FUNC_LOOKUP, 64'h33, 64'h100, '0);
        send_request(oaht_pkg::FUNC_INSERT, 64'h44, 64'h100, 64'ha4);
        send_request(oaht_pkg::FUNC_LKINS, 64'h33, 64'h100, 64'hff);
        send_request(oaht_pkg::FUNC_LOOKUP, 64'h44, 64'h100, '0);
        send_request(oaht_pkg::FUNC_LOOKUP, 64'h55, 64'h100, '0);
    endtask

    task automatic test_random(int count);
        int          sel;
        logic [63:0] key;
        logic [63:0] hash;
        for (int i = 0; i < PoolSize; i++) begin
            pool_key[i] = rand64();
            pool_hash[i] = rand64();
            if (i % 4 != 0) begin
                pool_hash[i][oaht_pkg::IndexBits-1:0] =
                    oaht_pkg::IndexBits'($urandom_range(0, 40));
            end
        end
        pool_key[1] = pool_key[0];
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80) begin
                sel = $urandom_range(PoolSize - 1);
                key = pool_key[sel];
                hash = pool_hash[sel];
            end else begin
                key = rand64();
                hash = rand64();
            end
            send_request(2'($urandom_range(3)), key, hash, rand64());
        end
    endtask

    task automatic test_fill_table();
        while (occupied_slots() < oaht_pkg::TableSize) begin
            last_key = rand64();
            last_hash = rand64();
            send_request($urandom_range(1) ? oaht_pkg::FUNC_INSERT : oaht_pkg::FUNC_LKINS,
                         last_key, last_hash, rand64());
        end
        send_request(oaht_pkg::FUNC_INSERT, rand64(), rand64(), rand64());
        send_request(oaht_pkg::FUNC_LKINS, rand64(), rand64(), rand64());
        send_request(oaht_pkg::FUNC_LOOKUP, rand64(), rand64(), '0);
        send_request(oaht_pkg::FUNC_REMOVE, last_key, last_hash, '0);
        send_request(oaht_pkg::FUNC_LOOKUP, rand64(), rand64(), '0);
        send_request(oaht_pkg::FUNC_REMOVE, rand64(), rand64(), '0);
        send_request(oaht_pkg::FUNC_INSERT, rand64(), rand64(), rand64());
        send_request(oaht_pkg::FUNC_INSERT, rand64(), rand64(), rand64());
        send_request(oaht_pkg::FUNC_LOOKUP, last_key, last_hash, '0);
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < oaht_pkg::TableSize; i++) slot_kind_m[i] = oaht_pkg::KIND_EMPTY;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 67;
        test_basic_ops();
        test_collisions();
        test_random(110);
        send_idle_pct = 67;
        recv_idle_pct = 29;
        test_random(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);
        test_fill_table();

        wait (pending_results.size() == 0);
        repeat (oaht_pkg::TableSize + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
